/* sv/mqrx_pkg.sv */
`timescale 1ns / 1ps

package mqrx_pkg;

  // parser phase
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_BODY   = 2'd2,
    PH_HALT   = 2'd3
  } phase_t;

  // tag of a streamed data byte
  typedef enum logic [1:0] {
    BK_NONE    = 2'd0,
    BK_TOPIC   = 2'd1,
    BK_MESSAGE = 2'd2
  } byte_kind_t;

  // packet events
  typedef enum logic [3:0] {
    EV_NONE           = 4'd0,
    EV_CONNECTED      = 4'd1,
    EV_PUB_DONE       = 4'd2,
    EV_SUBACK_OK      = 4'd3,
    EV_SUBACK_REFUSED = 4'd4,
    EV_UNSUBACK       = 4'd5,
    EV_BAD_TYPE       = 4'd6,
    EV_BAD_LENGTH     = 4'd7,
    EV_MALFORMED      = 4'd8,
    EV_REFUSED        = 4'd9,
    EV_UNEXPECTED     = 4'd10
  } event_t;

  // control packet types
  localparam logic [3:0] T_CONNACK  = 4'd2;
  localparam logic [3:0] T_PUBLISH  = 4'd3;
  localparam logic [3:0] T_SUBACK   = 4'd9;
  localparam logic [3:0] T_UNSUBACK = 4'd11;
  localparam logic [3:0] T_MIN      = 4'd1;
  localparam logic [3:0] T_MAX      = 4'd14;

  // highest granted qos in a suback return code
  localparam logic [7:0] SUBACK_RC_MAX = 8'd2;

  // result queue between parser and output stage
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // one result word
  typedef struct packed {
    byte_kind_t  kind;
    logic [7:0]  data;
    event_t      ev;
    logic [3:0]  flags;
    logic [15:0] ident;
    logic [7:0]  ret;
    logic [7:0]  ack;
  } res_t;

endpackage

/* sv/mqtt_rx_packet_parser.sv */
`timescale 1ns / 1ps

// Receive-side MQTT 3.1.1 packet parser. Takes one received byte per word on
// the slave stream and parses the fixed header, the remaining length and the
// body of CONNACK, PUBLISH, SUBACK and UNSUBACK packets. PUBLISH topic and
// message bytes come out tagged in tuser; packet events (connected, publish
// done, suback, unsuback and the error codes) come out in tdata on the byte
// that ends the packet, or on the offending byte for a bad type or a bad
// length. A fatal error halts the parser: later bytes are still taken but
// ignored until reset. One byte is accepted every clock while the result
// queue has room; the parser state is updated on each accepted byte, and
// results pass through a four-word queue and then an output register;
// s_axis_tready falls only when that queue fills under downstream
// back-pressure.

module mqtt_rx_packet_parser import mqrx_pkg::*; #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // data_byte, event_res, header_flags,
                                      // packet_ident, ret_code, ack_byte
  output logic [1:0]  m_axis_tuser    // byte_kind
);

  logic byte_accept;
  logic res_push;
  res_t res;
  logic q_full;
  logic q_pop;
  logic q_valid;
  res_t q_head;

  assign s_axis_tready = !q_full;
  assign byte_accept   = s_axis_tvalid && s_axis_tready;

  // front: byte parser
  mqrx_parser #(
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .byte_accept (byte_accept),
    .rx_byte     (s_axis_tdata),
    .res_push    (res_push),
    .res         (res)
  );

  // result queue
  mqrx_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (res_push),
    .push_res   (res),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_res   (q_head)
  );

  // back: output stage
  mqrx_out u_out (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (q_valid),
    .head_res      (q_head),
    .pop           (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

/* sv/mqrx_parser.sv */
`timescale 1ns / 1ps

module mqrx_parser import mqrx_pkg::*; #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_accept,
  input  logic [7:0] rx_byte,
  output logic       res_push,
  output res_t       res
);

  localparam int LEN_W = 7 * MAX_LENGTH_BYTES;
  localparam int IW    = (MAX_LENGTH_BYTES > 1) ? $clog2(MAX_LENGTH_BYTES) : 1;
  localparam int CW    = ((LEN_W > 16) ? LEN_W : 16) + 2;

  phase_t            phase, phase_next;
  logic [3:0]        pkt_kind, pkt_kind_next;
  logic [3:0]        flag_nibble, flag_nibble_next;
  logic [LEN_W-1:0]  length_accum, length_accum_next;
  logic [IW-1:0]     length_index, length_index_next;
  logic [LEN_W-1:0]  body_pos, body_pos_next;
  logic [15:0]       topic_len, topic_len_next;
  logic [7:0]        head_bytes [3];
  logic [7:0]        head_bytes_next [3];

  logic [LEN_W-1:0]  accum_upd;
  logic [LEN_W-1:0]  pos_inc;
  logic [7:0]        head_cur [3];
  logic [15:0]       topic_cur;
  logic [LEN_W-1:0]  fin_len;
  logic [15:0]       fin_topic;
  logic              pub_ok;
  logic              last_len_byte;
  logic              body_end;
  logic [3:0]        hdr_type;

  event_t            fin_ev;
  logic              fin_fatal;
  logic [15:0]       fin_ident;
  logic [7:0]        fin_ret;
  logic [7:0]        fin_ack;

  // working values for the current word
  always_comb begin
    hdr_type      = rx_byte[7:4];
    accum_upd     = length_accum | (LEN_W'(rx_byte[6:0]) << (7 * length_index));
    last_len_byte = (length_index == IW'(MAX_LENGTH_BYTES - 1));
    pos_inc       = body_pos + 1'b1;
    body_end      = (pos_inc >= length_accum);
    head_cur      = head_bytes;
    topic_cur     = topic_len;
    if (phase == PH_BODY) begin
      if (body_pos < LEN_W'(3)) head_cur[body_pos[1:0]] = rx_byte;
      if (pkt_kind == T_PUBLISH && body_pos == LEN_W'(1)) begin
        topic_cur = {head_bytes[0], rx_byte};
      end
    end
    if (phase == PH_LENGTH) begin
      fin_len   = accum_upd;
      fin_topic = 16'd0;
    end else begin
      fin_len   = length_accum;
      fin_topic = topic_cur;
    end
    pub_ok = (fin_len >= LEN_W'(2)) && (CW'(fin_len) >= CW'(fin_topic) + CW'(2));
  end

  // packet end evaluation
  always_comb begin
    fin_ev    = EV_NONE;
    fin_fatal = 1'b0;
    fin_ident = 16'd0;
    fin_ret   = 8'd0;
    fin_ack   = 8'd0;
    case (pkt_kind)
      T_CONNACK: begin
        if (fin_len < LEN_W'(2)) begin
          fin_ev    = EV_MALFORMED;
          fin_fatal = 1'b1;
        end else begin
          fin_ack = head_cur[0];
          fin_ret = head_cur[1];
          if (head_cur[1] != 8'd0) begin
            fin_ev    = EV_REFUSED;
            fin_fatal = 1'b1;
          end else begin
            fin_ev = EV_CONNECTED;
          end
        end
      end
      T_PUBLISH: begin
        if (!pub_ok) begin
          fin_ev    = EV_MALFORMED;
          fin_fatal = 1'b1;
        end else begin
          fin_ev = EV_PUB_DONE;
        end
      end
      T_SUBACK: begin
        if (fin_len < LEN_W'(3)) begin
          fin_ev    = EV_MALFORMED;
          fin_fatal = 1'b1;
        end else begin
          fin_ident = {head_cur[0], head_cur[1]};
          fin_ret   = head_cur[2];
          fin_ev    = (head_cur[2] > SUBACK_RC_MAX) ? EV_SUBACK_REFUSED : EV_SUBACK_OK;
        end
      end
      T_UNSUBACK: begin
        if (fin_len < LEN_W'(2)) begin
          fin_ev    = EV_MALFORMED;
          fin_fatal = 1'b1;
        end else begin
          fin_ident = {head_cur[0], head_cur[1]};
          fin_ev    = EV_UNSUBACK;
        end
      end
      default: begin
        fin_ev    = EV_UNEXPECTED;
        fin_fatal = 1'b1;
      end
    endcase
  end

  // next state
  always_comb begin
    phase_next        = phase;
    pkt_kind_next     = pkt_kind;
    flag_nibble_next  = flag_nibble;
    length_accum_next = length_accum;
    length_index_next = length_index;
    body_pos_next     = body_pos;
    topic_len_next    = topic_len;
    head_bytes_next   = head_bytes;
    if (byte_accept) begin
      case (phase)
        PH_HEADER: begin
          flag_nibble_next = rx_byte[3:0];
          if (hdr_type < T_MIN || hdr_type > T_MAX) begin
            phase_next = PH_HALT;
          end else begin
            pkt_kind_next     = hdr_type;
            length_accum_next = '0;
            length_index_next = '0;
            phase_next        = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          length_accum_next = accum_upd;
          if (rx_byte[7]) begin
            if (last_len_byte) phase_next = PH_HALT;
            else length_index_next = length_index + 1'b1;
          end else begin
            body_pos_next  = '0;
            topic_len_next = 16'd0;
            if (accum_upd == '0) phase_next = fin_fatal ? PH_HALT : PH_HEADER;
            else phase_next = PH_BODY;
          end
        end
        PH_BODY: begin
          head_bytes_next = head_cur;
          topic_len_next  = topic_cur;
          body_pos_next   = pos_inc;
          if (body_end) phase_next = fin_fatal ? PH_HALT : PH_HEADER;
        end
        default: begin
          phase_next = PH_HALT;
        end
      endcase
    end
  end

  // result word
  always_comb begin
    res       = '0;
    res.kind  = BK_NONE;
    res.ev    = EV_NONE;
    res.flags = flag_nibble_next;
    case (phase)
      PH_HEADER: begin
        if (hdr_type < T_MIN || hdr_type > T_MAX) res.ev = EV_BAD_TYPE;
      end
      PH_LENGTH: begin
        if (rx_byte[7]) begin
          if (last_len_byte) res.ev = EV_BAD_LENGTH;
        end else if (accum_upd == '0) begin
          res.ev    = fin_ev;
          res.ident = fin_ident;
          res.ret   = fin_ret;
          res.ack   = fin_ack;
        end
      end
      PH_BODY: begin
        if (pkt_kind == T_PUBLISH && body_pos >= LEN_W'(2) && pub_ok) begin
          res.kind = (CW'(body_pos) - CW'(2) < CW'(topic_cur)) ? BK_TOPIC : BK_MESSAGE;
          res.data = rx_byte;
        end
        if (body_end) begin
          res.ev    = fin_ev;
          res.ident = fin_ident;
          res.ret   = fin_ret;
          res.ack   = fin_ack;
        end
      end
      default: begin
        res.ev = EV_NONE;
      end
    endcase
    res_push = byte_accept && (res.kind != BK_NONE || res.ev != EV_NONE);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      pkt_kind      <= 4'd0;
      flag_nibble   <= 4'd0;
      length_accum  <= '0;
      length_index  <= '0;
      body_pos      <= '0;
      topic_len     <= 16'd0;
      head_bytes[0] <= 8'd0;
      head_bytes[1] <= 8'd0;
      head_bytes[2] <= 8'd0;
    end else begin
      phase        <= phase_next;
      pkt_kind     <= pkt_kind_next;
      flag_nibble  <= flag_nibble_next;
      length_accum <= length_accum_next;
      length_index <= length_index_next;
      body_pos     <= body_pos_next;
      topic_len    <= topic_len_next;
      head_bytes   <= head_bytes_next;
    end
  end

endmodule

/* sv/mqrx_fifo.sv */
`timescale 1ns / 1ps

module mqrx_fifo import mqrx_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_res,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output res_t head_res
);

  res_t             slots [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QAW:0]     count;
  logic             do_push;
  logic             do_pop;

  // flags and head
  assign full       = (count == (QAW+1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_res   = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_res;
  end

endmodule

/* sv/mqrx_out.sv */
`timescale 1ns / 1ps

module mqrx_out import mqrx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  res_t        head_res,
  output logic        pop,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser
);

  logic out_valid;
  res_t out_res;

  // take the queue head when the output register is free or draining
  assign pop = head_valid && (!out_valid || m_axis_tready);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_res <= head_res;
  end

  // word packing
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.kind;
  assign m_axis_tdata  = {out_res.ack, out_res.ret, out_res.ident,
                          out_res.flags, out_res.ev, out_res.data};

endmodule
